// ===== src/mfde_pkg.sv =====
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared constants, types and the 5x7 glyph table of the framebuffer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfde_pkg;

  localparam int PANEL_WIDTH  = 200;
  localparam int PANEL_HEIGHT = 200;
  localparam int ROW_BYTES    = PANEL_WIDTH / 8;
  localparam int FRAME_BYTES  = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);
  localparam int XW           = $clog2(PANEL_WIDTH + 1);
  localparam int YW           = $clog2(PANEL_HEIGHT + 1);
  localparam int BW           = XW - 3;
  localparam int CW           = 13;
  localparam int GLYPH_W      = 5;
  localparam int GLYPH_H      = 7;
  localparam int GLYPH_BITS   = GLYPH_W * GLYPH_H;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_FILL    = 3'd1;
  localparam logic [2:0] OP_OUTLINE = 3'd2;
  localparam logic [2:0] OP_CHAR    = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] PK_BOX   = 2'd0;
  localparam logic [1:0] PK_CLEAR = 2'd1;
  localparam logic [1:0] PK_READ  = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [1:0]            kind;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic [9:0]            w;
    logic [9:0]            h;
    logic                  black;
    logic [12:0]           addr;
  } pnt_req_t;

  typedef struct packed {
    logic       idle;
    logic [7:0] data;
  } pnt_stat_t;

  function automatic logic [5:0] glyph_slot(input logic [7:0] ch);
    logic [7:0] u;
    u = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) u = ch - 8'h20;
    if (u >= 8'h41 && u <= 8'h5A) return 6'd16 + 6'(u - 8'h41);
    if (u >= 8'h30 && u <= 8'h39) return 6'd6 + 6'(u - 8'h30);
    case (u)
      8'h25:   return 6'd1;
      8'h2D:   return 6'd2;
      8'h2E:   return 6'd3;
      8'h3A:   return 6'd4;
      8'h2F:   return 6'd5;
      default: return 6'd0;
    endcase
  endfunction

  // rows top to bottom, each 5 bits with the leftmost dot in the MSB
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [5:0] slot);
    case (slot)
      6'd1:  return {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
      6'd2:  return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      6'd3:  return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      6'd4:  return {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
      6'd5:  return {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
      6'd6:  return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd7:  return {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
      6'd8:  return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd9:  return {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      6'd10: return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd11: return {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd12: return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd13: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd14: return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd15: return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      6'd16: return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd17: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      6'd18: return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      6'd19: return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      6'd20: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      6'd21: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd22: return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      6'd23: return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd24: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      6'd25: return {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      6'd26: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd27: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd28: return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      6'd29: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      6'd30: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd31: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd32: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd33: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      6'd34: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd35: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd36: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd37: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd38: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      6'd39: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      6'd40: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd41: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== src/mfde_painter.sv =====
// ----------------------------------------------------------------------------
// mfde_painter
// Frame memory with a byte-wise box painter, fill sweep and byte read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_painter import mfde_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pnt_req_t  req_i,
  output pnt_stat_t      stat_o
);

  localparam logic [3:0] P_IDLE  = 4'd0;
  localparam logic [3:0] P_FILL  = 4'd1;
  localparam logic [3:0] P_SETUP = 4'd2;
  localparam logic [3:0] P_MUL   = 4'd3;
  localparam logic [3:0] P_RD    = 4'd4;
  localparam logic [3:0] P_WR    = 4'd5;
  localparam logic [3:0] P_RDA   = 4'd6;
  localparam logic [3:0] P_RDB   = 4'd7;

  logic [7:0] mem [FRAME_BYTES];

  logic [3:0]        state_q, state_d;
  pnt_req_t          req_q, req_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [7:0]        fill_q, fill_d;
  logic [XW-1:0]     x0_q, x0_d, x1m1_q, x1m1_d;
  logic [YW-1:0]     y_q, y_d, y1m1_q, y1m1_d;
  logic [BW-1:0]     b_q, b_d;
  logic [ADDR_W-1:0] rbase_q, rbase_d;
  logic [7:0]        data_q, data_d;
  logic [7:0]        rdata_q;

  logic signed [CW-1:0] cx0, cx1, cy0, cy1, xe, ye;
  logic [ADDR_W:0]      idx;
  logic                 in_range, first_b, last_b, addr_ok;
  logic [2:0]           lo, hi;
  logic [7:0]           mask;
  logic                 we;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [7:0]           wdata;

  always_comb begin
    xe  = req_q.x + $signed({{(CW-10){1'b0}}, req_q.w});
    ye  = req_q.y + $signed({{(CW-10){1'b0}}, req_q.h});
    cx0 = (req_q.x < 0) ? '0 : req_q.x;
    cy0 = (req_q.y < 0) ? '0 : req_q.y;
    cx1 = (xe > CW'(PANEL_WIDTH)) ? CW'(PANEL_WIDTH) : xe;
    cy1 = (ye > CW'(PANEL_HEIGHT)) ? CW'(PANEL_HEIGHT) : ye;
  end

  assign idx      = {1'b0, rbase_q} + (ADDR_W+1)'(b_q);
  assign in_range = idx < (ADDR_W+1)'(FRAME_BYTES);
  assign first_b  = b_q == x0_q[XW-1:3];
  assign last_b   = b_q == x1m1_q[XW-1:3];
  assign lo       = first_b ? x0_q[2:0] : 3'd0;
  assign hi       = last_b ? x1m1_q[2:0] : 3'd7;
  assign mask     = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
  assign addr_ok  = req_q.addr < 13'(FRAME_BYTES);

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    x0_d    = x0_q;
    x1m1_d  = x1m1_q;
    y_d     = y_q;
    y1m1_d  = y1m1_q;
    b_d     = b_q;
    rbase_d = rbase_q;
    data_d  = data_q;
    we      = 1'b0;
    waddr   = idx[ADDR_W-1:0];
    wdata   = req_q.black ? (rdata_q & ~mask) : (rdata_q | mask);
    raddr   = idx[ADDR_W-1:0];
    case (state_q)
      P_IDLE: begin
        if (req_i.start) begin
          req_d = req_i;
          case (req_i.kind)
            PK_CLEAR: begin
              fill_d  = req_i.black ? 8'h00 : 8'hFF;
              cnt_d   = '0;
              state_d = P_FILL;
            end
            PK_READ: state_d = P_RDA;
            default: state_d = P_SETUP;
          endcase
        end
      end
      P_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = fill_q;
        if (cnt_q == ADDR_W'(FRAME_BYTES - 1)) begin
          state_d = P_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      P_SETUP: begin
        x0_d   = XW'(cx0);
        x1m1_d = XW'(cx1 - 1'b1);
        y_d    = YW'(cy0);
        y1m1_d = YW'(cy1 - 1'b1);
        if (cx0 >= cx1 || cy0 >= cy1) begin
          state_d = P_IDLE;
        end else begin
          state_d = P_MUL;
        end
      end
      P_MUL: begin
        rbase_d = ADDR_W'(y_q * ROW_BYTES);
        b_d     = x0_q[XW-1:3];
        state_d = P_RD;
      end
      P_RD, P_WR: begin
        if (state_q == P_RD && in_range) begin
          state_d = P_WR;
        end else begin
          we = (state_q == P_WR);
          state_d = P_RD;
          if (!last_b) begin
            b_d = b_q + 1'b1;
          end else if (y_q == y1m1_q) begin
            state_d = P_IDLE;
          end else begin
            y_d     = y_q + 1'b1;
            rbase_d = rbase_q + ADDR_W'(ROW_BYTES);
            b_d     = x0_q[XW-1:3];
          end
        end
      end
      P_RDA: begin
        raddr   = addr_ok ? req_q.addr[ADDR_W-1:0] : '0;
        state_d = P_RDB;
      end
      P_RDB: begin
        data_d  = addr_ok ? rdata_q : 8'h00;
        state_d = P_IDLE;
      end
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_FILL;
      cnt_q   <= '0;
      fill_q  <= 8'h00;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    x0_q    <= x0_d;
    x1m1_q  <= x1m1_d;
    y_q     <= y_d;
    y1m1_q  <= y1m1_d;
    b_q     <= b_d;
    rbase_q <= rbase_d;
    data_q  <= data_d;
  end

  assign stat_o.idle = (state_q == P_IDLE);
  assign stat_o.data = data_q;

endmodule

`default_nettype wire

// ===== src/mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Command sequencer for a 1-bit packed framebuffer drawing engine.
//
//   channel  signals                       transfer
//   in       in_valid_i / in_ready_o       one drawing or read command
//   out      out_valid_o / out_ready_i     read_data_o, one per command
//
// After reset the frame memory is swept to zero, one byte a cycle;
// in_ready_o stays low meanwhile. Boxes go through one read-modify-write
// port of the frame memory; a glyph issues one box per set dot and skips
// each blank dot (35 dot slots). The next command is taken once the result
// is in the output register; a stalled output holds the last command's end.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_draw_engine import mfde_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [10:0] pos_x_i,
  input  wire logic [10:0] pos_y_i,
  input  wire logic [9:0]  rect_width_i,
  input  wire logic [9:0]  rect_height_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [3:0]  glyph_scale_i,
  input  wire logic        ink_black_i,
  input  wire logic [12:0] byte_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_ISSUE = 2'd1;
  localparam logic [1:0] T_WAIT  = 2'd2;
  localparam logic [1:0] T_FIN   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [2:0]            op_q;
  logic signed [CW-1:0]  x_q, y_q;
  logic [9:0]            w_q, h_q;
  logic [3:0]            s_q;
  logic                  black_q;
  logic [12:0]           addr_q;
  logic [GLYPH_BITS-1:0] glyph_q, glyph_d;
  logic [1:0]            k_q, k_d;
  logic [2:0]            r_q, r_d, c_q, c_d;
  logic [6:0]            ox_q, ox_d, oy_q, oy_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_data_q, out_data_d;

  pnt_req_t  req;
  pnt_stat_t stat;
  logic      accept, skip, last;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    req       = '0;
    req.black = black_q;
    req.addr  = addr_q;
    req.x     = x_q;
    req.y     = y_q;
    req.w     = w_q;
    req.h     = h_q;
    skip      = 1'b0;
    last      = 1'b1;
    case (op_q)
      OP_CLEAR: req.kind = PK_CLEAR;
      OP_READ:  req.kind = PK_READ;
      OP_OUTLINE: begin
        req.kind = PK_BOX;
        last     = (k_q == 2'd3);
        case (k_q)
          2'd0: req.h = 10'd1;
          2'd1: begin
            req.h = 10'd1;
            req.y = y_q + $signed({{(CW-10){1'b0}}, h_q}) - 1'b1;
          end
          2'd2: req.w = 10'd1;
          default: begin
            req.w = 10'd1;
            req.x = x_q + $signed({{(CW-10){1'b0}}, w_q}) - 1'b1;
          end
        endcase
      end
      OP_CHAR: begin
        req.kind = PK_BOX;
        req.x    = x_q + $signed({{(CW-7){1'b0}}, ox_q});
        req.y    = y_q + $signed({{(CW-7){1'b0}}, oy_q});
        req.w    = 10'(s_q);
        req.h    = 10'(s_q);
        skip     = !glyph_q[GLYPH_BITS-1];
        last     = (r_q == 3'(GLYPH_H - 1)) && (c_q == 3'(GLYPH_W - 1));
      end
      default: req.kind = PK_BOX;
    endcase
    req.start = (state_q == T_ISSUE) && stat.idle && !skip;
  end

  always_comb begin
    state_d     = state_q;
    glyph_d     = glyph_q;
    k_d         = k_q;
    r_d         = r_q;
    c_d         = c_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          glyph_d = glyph_bits(glyph_slot(char_code_i));
          k_d     = '0;
          r_d     = '0;
          c_d     = '0;
          ox_d    = '0;
          oy_d    = '0;
          if (opcode_i > OP_READ
              || (opcode_i == OP_OUTLINE && (rect_width_i == '0 || rect_height_i == '0))
              || (opcode_i == OP_CHAR && glyph_scale_i == '0)) begin
            state_d = T_FIN;
          end else begin
            state_d = T_ISSUE;
          end
        end
      end
      T_ISSUE, T_WAIT: begin
        if (stat.idle && (state_q == T_WAIT || skip)) begin
          if (last) begin
            state_d = T_FIN;
          end else begin
            state_d = T_ISSUE;
            k_d     = k_q + 1'b1;
            glyph_d = glyph_q << 1;
            if (c_q == 3'(GLYPH_W - 1)) begin
              c_d  = '0;
              ox_d = '0;
              r_d  = r_q + 1'b1;
              oy_d = oy_q + 7'(s_q);
            end else begin
              c_d  = c_q + 1'b1;
              ox_d = ox_q + 7'(s_q);
            end
          end
        end else if (req.start) begin
          state_d = T_WAIT;
        end
      end
      T_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = (op_q == OP_READ) ? stat.data : 8'h00;
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      x_q     <= CW'(signed'(pos_x_i));
      y_q     <= CW'(signed'(pos_y_i));
      w_q     <= rect_width_i;
      h_q     <= rect_height_i;
      s_q     <= glyph_scale_i;
      black_q <= ink_black_i;
      addr_q  <= byte_index_i;
    end
    glyph_q    <= glyph_d;
    k_q        <= k_d;
    r_q        <= r_d;
    c_q        <= c_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    out_data_q <= out_data_d;
  end

  mfde_painter u_painter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .stat_o (stat)
  );

  assign in_ready_o  = (state_q == T_IDLE) && stat.idle;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule

`default_nettype wire
